>>> hdl/cbsu_pkg.sv
`default_nettype none

package cbsu_pkg;

  // Field widths of the two channels.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned FLAGS_W  = 4;
  localparam int unsigned CYCLE_W  = 5;
  localparam int unsigned NUM_REGS = 8;

  // Register file slots: B, C, D, E, H, L, F, A.
  localparam logic [IDX_W-1:0] IDX_H   = 3'd4;
  localparam logic [IDX_W-1:0] IDX_L   = 3'd5;
  localparam logic [IDX_W-1:0] IDX_F   = 3'd6;
  // Operand code that selects the memory byte at HL.
  localparam logic [IDX_W-1:0] SEL_MEM = 3'd6;

  // Opcode groups, from bits 7..6 of the CB opcode.
  localparam logic [1:0] GRP_SHIFT = 2'd0;
  localparam logic [1:0] GRP_BIT   = 2'd1;
  localparam logic [1:0] GRP_RES   = 2'd2;
  localparam logic [1:0] GRP_SET   = 2'd3;

  // Command codes.
  localparam logic CMD_EXEC  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Machine cycle counts reported per beat.
  localparam logic [CYCLE_W-1:0] CYC_WRITE = 5'd0;
  localparam logic [CYCLE_W-1:0] CYC_REG   = 5'd8;
  localparam logic [CYCLE_W-1:0] CYC_MEM   = 5'd16;

  // Decoded operation kinds.
  typedef enum logic [3:0] {
    K_RLC,
    K_RRC,
    K_RL,
    K_RR,
    K_SLA,
    K_SRA,
    K_SWAP,
    K_SRL,
    K_BIT,
    K_RES,
    K_SET,
    K_WRITE
  } op_kind_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_kind_t             kind;
    logic [IDX_W-1:0]     bit_num;
    logic [IDX_W-1:0]     reg_sel;
    logic                 is_mem;
    logic [BYTE_W-1:0]    data;
  } uop_t;

endpackage : cbsu_pkg

`default_nettype wire

>>> hdl/cbsu_in_if.sv
`default_nettype none

interface cbsu_in_if
  import cbsu_pkg::*;
();

  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] opcode;
  logic [IDX_W-1:0]  reg_index;
  logic [BYTE_W-1:0] write_value;
  logic [BYTE_W-1:0] mem_value;

  modport source (
    output valid, command, opcode, reg_index, write_value, mem_value,
    input  ready
  );

  modport sink (
    input  valid, command, opcode, reg_index, write_value, mem_value,
    output ready
  );

endinterface : cbsu_in_if

`default_nettype wire

>>> hdl/cbsu_out_if.sv
`default_nettype none

interface cbsu_out_if
  import cbsu_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  result_value;
  logic               mem_write;
  logic [ADDR_W-1:0]  mem_address;
  logic [FLAGS_W-1:0] flags_out;
  logic [CYCLE_W-1:0] cycle_count;

  modport source (
    output valid, result_value, mem_write, mem_address, flags_out, cycle_count,
    input  ready
  );

  modport sink (
    input  valid, result_value, mem_write, mem_address, flags_out, cycle_count,
    output ready
  );

endinterface : cbsu_out_if

`default_nettype wire

>>> hdl/cb_prefix_bit_shift_unit.sv
// An accepted beat waits in the queue, then executes into the output register.
// Throughput: one instruction or register write per cycle while the output is not
// stalled; the execute stage reads and writes the register file in the same cycle.
// A small queue between decode and execute absorbs output stalls.
// Reset (rst_n low, synchronous) clears the register file, the queue and the output.
`default_nettype none

module cb_prefix_bit_shift_unit
  import cbsu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  cbsu_in_if.sink     in_ch,
  cbsu_out_if.source  out_ch
);

  logic push_valid;
  logic push_ready;
  uop_t push_uop;
  logic pop_valid;
  logic pop_ready;
  uop_t pop_uop;

  // Decode and classify incoming beats.
  cbsu_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop)
  );

  // Decouple decode from execute.
  cbsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_uop    (pop_uop)
  );

  // Execute against the register file and register the result.
  cbsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_uop   (pop_uop),
    .out_ch    (out_ch)
  );

endmodule : cb_prefix_bit_shift_unit

`default_nettype wire

>>> hdl/cbsu_front.sv
`default_nettype none

module cbsu_front
  import cbsu_pkg::*;
(
  cbsu_in_if.sink in_ch,
  output logic    push_valid,
  input  wire     push_ready,
  output uop_t    push_uop
);

  logic [1:0]       grp;
  logic [IDX_W-1:0] bn;
  logic [IDX_W-1:0] sel;

  assign grp = in_ch.opcode[7:6];
  assign bn  = in_ch.opcode[5:3];
  assign sel = in_ch.opcode[2:0];

  // Handshake passes straight to the queue.
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  // Classify the beat into one operation kind and pick its operand source.
  always_comb begin
    push_uop.bit_num = bn;
    if (in_ch.command == CMD_WRITE) begin
      push_uop.kind    = K_WRITE;
      push_uop.reg_sel = in_ch.reg_index;
      push_uop.is_mem  = 1'b0;
      push_uop.data    = in_ch.write_value;
    end else begin
      push_uop.reg_sel = sel;
      push_uop.is_mem  = (sel == SEL_MEM);
      push_uop.data    = in_ch.mem_value;
      case (grp)
        GRP_SHIFT: begin
          case (bn)
            3'd0:    push_uop.kind = K_RLC;
            3'd1:    push_uop.kind = K_RRC;
            3'd2:    push_uop.kind = K_RL;
            3'd3:    push_uop.kind = K_RR;
            3'd4:    push_uop.kind = K_SLA;
            3'd5:    push_uop.kind = K_SRA;
            3'd6:    push_uop.kind = K_SWAP;
            default: push_uop.kind = K_SRL;
          endcase
        end
        GRP_BIT: push_uop.kind = K_BIT;
        GRP_RES: push_uop.kind = K_RES;
        default: push_uop.kind = K_SET;
      endcase
    end
  end

endmodule : cbsu_front

`default_nettype wire

>>> hdl/cbsu_queue.sv
`default_nettype none

module cbsu_queue
  import cbsu_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push_valid,
  output logic push_ready,
  input  uop_t push_uop,
  output logic pop_valid,
  input  wire  pop_ready,
  output uop_t pop_uop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  uop_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_uop    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_uop;
    end
  end

  // The fill count never runs past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue fill count exceeds depth");

  // A full queue with no pop stays full and keeps its write pointer.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == FULL_CNT) && !pop |=> (count_r == FULL_CNT) && $stable(wr_ptr_r))
    else $error("full queue changed without a pop");

  // Both pointers meet whenever the queue is empty or full; the check covers the empty case.
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with mismatched pointers");

endmodule : cbsu_queue

`default_nettype wire

>>> hdl/cbsu_back.sv
`default_nettype none

module cbsu_back
  import cbsu_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         pop_valid,
  output logic        pop_ready,
  input  uop_t        pop_uop,
  cbsu_out_if.source  out_ch
);

  logic [BYTE_W-1:0]  rf_r [NUM_REGS];
  logic [BYTE_W-1:0]  rf_nxt [NUM_REGS];
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_result_r;
  logic               out_mem_write_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [FLAGS_W-1:0] out_flags_r;
  logic [CYCLE_W-1:0] out_cycles_r;

  logic               exec;
  logic [BYTE_W-1:0]  f_cur;
  logic [BYTE_W-1:0]  f_new;
  logic [BYTE_W-1:0]  v;
  logic               cin;
  logic               c;
  logic [BYTE_W-1:0]  res;
  logic               do_mem_write;
  logic [CYCLE_W-1:0] cycles;

  // Take a beat when the output register is empty or being drained.
  assign pop_ready = !out_valid_r || out_ch.ready;
  assign exec      = pop_valid && pop_ready;

  assign f_cur = rf_r[IDX_F];
  assign cin   = f_cur[4];
  assign v     = pop_uop.is_mem ? pop_uop.data : rf_r[pop_uop.reg_sel];

  // Shift, rotate and bit unit with flag update.
  always_comb begin
    c     = 1'b0;
    res   = v;
    f_new = f_cur;
    case (pop_uop.kind)
      K_RLC:   begin c = v[7]; res = {v[6:0], v[7]};        end
      K_RRC:   begin c = v[0]; res = {v[0], v[7:1]};        end
      K_RL:    begin c = v[7]; res = {v[6:0], cin};         end
      K_RR:    begin c = v[0]; res = {cin, v[7:1]};         end
      K_SLA:   begin c = v[7]; res = {v[6:0], 1'b0};        end
      K_SRA:   begin c = v[0]; res = {v[7], v[7:1]};        end
      K_SWAP:  begin c = 1'b0; res = {v[3:0], v[7:4]};      end
      K_SRL:   begin c = v[0]; res = {1'b0, v[7:1]};        end
      K_BIT:   res = v;
      K_RES:   res = v & ~(BYTE_W'(1) << pop_uop.bit_num);
      K_SET:   res = v | (BYTE_W'(1) << pop_uop.bit_num);
      K_WRITE: res = pop_uop.data;
      default: res = v;
    endcase
    case (pop_uop.kind)
      K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SWAP, K_SRL: begin
        f_new = {(res == '0), 1'b0, 1'b0, c, f_cur[3:0]};
      end
      K_BIT: begin
        f_new = {!v[pop_uop.bit_num], 1'b0, 1'b1, f_cur[4:0]};
      end
      default: f_new = f_cur;
    endcase
  end

  // Register file write-back; executed opcodes always rewrite F.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      rf_nxt[i] = rf_r[i];
    end
    do_mem_write = 1'b0;
    if (exec) begin
      if (pop_uop.kind == K_WRITE) begin
        rf_nxt[pop_uop.reg_sel] = pop_uop.data;
      end else begin
        if (pop_uop.kind != K_BIT) begin
          if (pop_uop.is_mem) begin
            do_mem_write = 1'b1;
          end else begin
            rf_nxt[pop_uop.reg_sel] = res;
          end
        end
        rf_nxt[IDX_F] = f_new;
      end
    end
  end

  always_comb begin
    if (pop_uop.kind == K_WRITE) begin
      cycles = CYC_WRITE;
    end else if (pop_uop.is_mem) begin
      cycles = CYC_MEM;
    end else begin
      cycles = CYC_REG;
    end
  end

  assign out_valid_nxt = exec ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
    end
  end

  // Output payload register, loaded with each executed beat.
  always_ff @(posedge clk) begin
    if (exec) begin
      out_result_r    <= res;
      out_mem_write_r <= do_mem_write;
      out_addr_r      <= {rf_r[IDX_H], rf_r[IDX_L]};
      out_flags_r     <= rf_nxt[IDX_F][7:4];
      out_cycles_r    <= cycles;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_result_r;
  assign out_ch.mem_write    = out_mem_write_r;
  assign out_ch.mem_address  = out_addr_r;
  assign out_ch.flags_out    = out_flags_r;
  assign out_ch.cycle_count  = out_cycles_r;

  // A memory write-back always comes from a memory operand.
  a_mem_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mem_write_r |-> (out_cycles_r == CYC_MEM))
    else $error("memory write-back without memory cycle count");

  // A register write never asks for a memory write-back.
  a_write_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cycles_r == CYC_WRITE) |-> !out_mem_write_r)
    else $error("register write flagged as memory write");

  // Nothing but a register write touches the low nibble of F.
  a_f_low: assert property (@(posedge clk) disable iff (!rst_n)
    !(exec && (pop_uop.kind == K_WRITE)) |=> $stable(rf_r[IDX_F][3:0]))
    else $error("low nibble of F changed by an executed opcode");

endmodule : cbsu_back

`default_nettype wire

>>> tb/sv/cb_prefix_bit_shift_unit_tb.sv
`timescale 1ns / 100ps

module cb_prefix_bit_shift_unit_tb;
  import cbsu_pkg::*;

  // Register slots that the stimulus names directly.
  localparam logic [IDX_W-1:0] REG_B = 3'd0;
  localparam logic [IDX_W-1:0] REG_C = 3'd1;
  localparam logic [IDX_W-1:0] REG_A = 3'd7;

  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam int unsigned HOLD_CYCLES     = 64;
  localparam int unsigned NUM_DIR_ROWS    = 24;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] opcode;
    logic [IDX_W-1:0]  reg_index;
    logic [BYTE_W-1:0] write_value;
    logic [BYTE_W-1:0] mem_value;
  } cb_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  result_value;
    logic               mem_write;
    logic [ADDR_W-1:0]  mem_address;
    logic [FLAGS_W-1:0] flags_out;
    logic [CYCLE_W-1:0] cycle_count;
  } cb_result_t;

  typedef struct packed {
    cb_beat_t   beat;
    logic       has_golden;
    cb_result_t golden;
  } dir_row_t;

  logic clk;
  logic rst_n;

  cbsu_in_if  in_bus ();
  cbsu_out_if out_bus ();

  cb_prefix_bit_shift_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Shadow copy of the register file and the results still owed by the block.
  logic [BYTE_W-1:0] shadow_regs [NUM_REGS];
  cb_result_t        pending_results [$];
  int unsigned       mismatch_count;

  // Idle and stall rates in percent, and hold-off requests for the receiver.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_seen;
  int unsigned hold_left;

  // Directed rows. Golden results are typed in only where they are obvious.
  dir_row_t dir_table [NUM_DIR_ROWS] = '{
    // Fresh reset: rotate of a zero register sets Z.
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RLC), REG_B}, 3'd0, 8'h00, 8'h00}, 1'b1,
      '{8'h00, 1'b0, 16'h0000, 4'b1000, CYC_REG}},
    // Memory operand: top bit rotates into carry and bit 0.
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RLC), SEL_MEM}, 3'd0, 8'h00, 8'h80}, 1'b1,
      '{8'h01, 1'b1, 16'h0000, 4'b0001, CYC_MEM}},
    // Load HL to its top value; the address shows HL from before the beat.
    '{'{CMD_WRITE, 8'h00, IDX_H, 8'hFF, 8'h00}, 1'b1,
      '{8'hFF, 1'b0, 16'h0000, 4'b0001, CYC_WRITE}},
    '{'{CMD_WRITE, 8'h00, IDX_L, 8'hFF, 8'h00}, 1'b1,
      '{8'hFF, 1'b0, 16'hFF00, 4'b0001, CYC_WRITE}},
    '{'{CMD_WRITE, 8'h00, REG_A, 8'h81, 8'h00}, 1'b1,
      '{8'h81, 1'b0, 16'hFFFF, 4'b0001, CYC_WRITE}},
    // Every rotate and shift on A but RLC.
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RRC), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RL), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RR), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_SLA), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_SRA), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_SWAP), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_SRL), REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    // BIT on memory never writes back.
    '{'{CMD_EXEC, {GRP_BIT, 3'd7, SEL_MEM}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_BIT, 3'd0, SEL_MEM}, 3'd0, 8'h00, 8'hFF}, 1'b0, '0},
    // RES and SET at the extreme bit numbers, on memory and on registers.
    '{'{CMD_EXEC, {GRP_RES, 3'd7, SEL_MEM}, 3'd0, 8'h00, 8'hFF}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SET, 3'd0, SEL_MEM}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_SET, 3'd7, REG_A}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_RES, 3'd0, REG_B}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    // Writing F sets all four flags and its low nibble.
    '{'{CMD_WRITE, 8'h00, IDX_F, 8'hFF, 8'h00}, 1'b1,
      '{8'hFF, 1'b0, 16'hFFFF, 4'b1111, CYC_WRITE}},
    // Carry in rotates into an empty register; low nibble of F must survive.
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RL), REG_C}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_WRITE, 8'h00, IDX_F, 8'h00, 8'h00}, 1'b1,
      '{8'h00, 1'b0, 16'hFFFF, 4'b0000, CYC_WRITE}},
    // SWAP of a zero memory byte: Z set, carry clear.
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_SWAP), SEL_MEM}, 3'd0, 8'h00, 8'h00}, 1'b1,
      '{8'h00, 1'b1, 16'hFFFF, 4'b1000, CYC_MEM}},
    // Operate on H and L themselves; the rotate of H moves the memory address.
    '{'{CMD_EXEC, {GRP_SHIFT, 3'(K_RR), IDX_H}, 3'd0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_EXEC, {GRP_BIT, 3'd0, IDX_L}, 3'd0, 8'h00, 8'h00}, 1'b0, '0}
  };

  // Clock.
  always #2 clk = ~clk;

  // Predicts one beat and updates the shadow register file.
  function automatic cb_result_t cb_execute(input cb_beat_t b);
    cb_result_t        r;
    logic [BYTE_W-1:0] operand;
    logic [BYTE_W-1:0] res;
    logic [BYTE_W-1:0] f;
    logic [IDX_W-1:0]  sel;
    logic [IDX_W-1:0]  bit_num;
    logic              carry_out;
    op_kind_t          kind;
    r.mem_address = {shadow_regs[IDX_H], shadow_regs[IDX_L]};
    r.mem_write = 1'b0;
    if (b.command == CMD_WRITE) begin
      shadow_regs[b.reg_index] = b.write_value;
      r.result_value = b.write_value;
      r.cycle_count = CYC_WRITE;
    end else begin
      sel = b.opcode[2:0];
      bit_num = b.opcode[5:3];
      operand = (sel == SEL_MEM) ? b.mem_value : shadow_regs[sel];
      f = shadow_regs[IDX_F];
      carry_out = 1'b0;
      case (b.opcode[7:6])
        GRP_SHIFT: kind = op_kind_t'({1'b0, bit_num});
        GRP_BIT:   kind = K_BIT;
        GRP_RES:   kind = K_RES;
        default:   kind = K_SET;
      endcase
      case (kind)
        K_RLC: begin
          carry_out = operand[7];
          res = {operand[6:0], operand[7]};
        end
        K_RRC: begin
          carry_out = operand[0];
          res = {operand[0], operand[7:1]};
        end
        K_RL: begin
          carry_out = operand[7];
          res = {operand[6:0], f[4]};
        end
        K_RR: begin
          carry_out = operand[0];
          res = {f[4], operand[7:1]};
        end
        K_SLA: begin
          carry_out = operand[7];
          res = {operand[6:0], 1'b0};
        end
        K_SRA: begin
          carry_out = operand[0];
          res = {operand[7], operand[7:1]};
        end
        K_SWAP: res = {operand[3:0], operand[7:4]};
        K_SRL: begin
          carry_out = operand[0];
          res = {1'b0, operand[7:1]};
        end
        K_BIT:   res = operand;
        K_RES:   res = operand & ~(8'h01 << bit_num);
        default: res = operand | (8'h01 << bit_num);
      endcase
      // Flags sit in F[7:4] as Z, N, H, C; the low nibble is never touched here.
      if (kind < K_BIT) begin
        f = {(res == '0), 1'b0, 1'b0, carry_out, f[3:0]};
      end else if (kind == K_BIT) begin
        f = {~operand[bit_num], 1'b0, 1'b1, f[4], f[3:0]};
      end
      if (kind != K_BIT) begin
        if (sel == SEL_MEM) begin
          r.mem_write = 1'b1;
        end else begin
          shadow_regs[sel] = res;
        end
      end
      shadow_regs[IDX_F] = f;
      r.result_value = res;
      r.cycle_count = (sel == SEL_MEM) ? CYC_MEM : CYC_REG;
    end
    r.flags_out = shadow_regs[IDX_F][7:4];
    return r;
  endfunction

  // Mostly random bytes, with the two extremes mixed in.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic cb_beat_t random_beat();
    cb_beat_t b;
    b.command = ($urandom_range(4) == 0) ? CMD_WRITE : CMD_EXEC;
    b.opcode = 8'($urandom_range(255));
    b.reg_index = 3'($urandom_range(7));
    b.write_value = pick_byte();
    b.mem_value = pick_byte();
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one beat after a random idle gap and books its expected result.
  task automatic send_beat(input cb_beat_t b, input logic has_golden,
                           input cb_result_t golden);
    cb_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= b.command;
    in_bus.opcode      <= b.opcode;
    in_bus.reg_index   <= b.reg_index;
    in_bus.write_value <= b.write_value;
    in_bus.mem_value   <= b.mem_value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = cb_execute(b);
    pending_results.push_back(has_golden ? golden : predicted);
  endtask

  // Stops offering and waits until every booked result has come out.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    cb_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_bus.result_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.result_value !== want.result_value)
          report_mismatch("result_value", out_bus.result_value, want.result_value);
        if (out_bus.mem_write !== want.mem_write)
          report_mismatch("mem_write", out_bus.mem_write, want.mem_write);
        if (out_bus.mem_address !== want.mem_address)
          report_mismatch("mem_address", out_bus.mem_address, want.mem_address);
        if (out_bus.flags_out !== want.flags_out)
          report_mismatch("flags_out", out_bus.flags_out, want.flags_out);
        if (out_bus.cycle_count !== want.cycle_count)
          report_mismatch("cycle_count", out_bus.cycle_count, want.cycle_count);
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("cb_prefix_bit_shift_unit_tb: FAIL");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int unsigned phase_send [4];
    int unsigned phase_recv [4];
    phase_send = '{0, 57, 0, 25};
    phase_recv = '{0, 0, 57, 25};
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_EXEC;
    in_bus.opcode = '0;
    in_bus.reg_index = '0;
    in_bus.write_value = '0;
    in_bus.mem_value = '0;
    out_bus.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    hold_seen = 0;
    hold_left = 0;
    mismatch_count = 0;
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      send_beat(dir_table[i].beat, dir_table[i].has_golden, dir_table[i].golden);
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // First phase: hold the output off while the input keeps pushing.
      if (p == 0) hold_requests++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_beat(random_beat(), 1'b0, '0);
      end
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("cb_prefix_bit_shift_unit_tb: PASS");
    end else begin
      $display("cb_prefix_bit_shift_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/cbsu_pkg.sv
hdl/cbsu_in_if.sv
hdl/cbsu_out_if.sv
hdl/cbsu_front.sv
hdl/cbsu_queue.sv
hdl/cbsu_back.sv
hdl/cb_prefix_bit_shift_unit.sv
tb/sv/cb_prefix_bit_shift_unit_tb.sv
